// File: rtl/core/totp_code_generator_macros.svh
// ---------------------------------------------------------------------------
// TOTP code generator assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef TOTP_CODE_GENERATOR_MACROS_SVH
`define TOTP_CODE_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOTP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/totp_pkg.sv
// ---------------------------------------------------------------------------
// TOTP package
// Shared types and SHA-1 constants for the TOTP code generator.
// ---------------------------------------------------------------------------
package totp_pkg;

    localparam int KEY_WORDS = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CODE_W    = 20;
    localparam int TS_W      = 32;
    localparam int RND_W     = 7;
    localparam int BLK_W     = 2;

    localparam logic [RND_W-1:0] LAST_ROUND    = 7'd79;
    localparam logic [RND_W-1:0] LAST_MOD_STEP = 7'd2;
    localparam logic [BLK_W-1:0] LAST_BLOCK    = 2'd3;

    localparam logic [BLK_W-1:0] BLK_INNER_KEY = 2'd0;
    localparam logic [BLK_W-1:0] BLK_INNER_MSG = 2'd1;
    localparam logic [BLK_W-1:0] BLK_OUTER_KEY = 2'd2;
    localparam logic [BLK_W-1:0] BLK_OUTER_MSG = 2'd3;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [31:0] IPAD      = 32'h36363636;
    localparam logic [31:0] OPAD      = 32'h5c5c5c5c;
    localparam logic [31:0] PAD_WORD  = 32'h80000000;
    localparam logic [31:0] INNER_LEN = 32'd576;
    localparam logic [31:0] OUTER_LEN = 32'd672;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_START,
        OP_LOAD,
        OP_ROUND,
        OP_ADD,
        OP_TRUNC,
        OP_MOD,
        OP_OUT
    } totp_op_t;

    typedef struct packed {
        totp_op_t         op;
        logic [BLK_W-1:0] blk;
        logic [RND_W-1:0] rnd;
    } totp_cmd_t;

endpackage

// File: rtl/core/totp_datapath.sv
// ---------------------------------------------------------------------------
// TOTP datapath
// Key registers, one SHA-1 round per cycle, truncation and reciprocal modulo.
// ---------------------------------------------------------------------------
module totp_datapath #(
    parameter int CODE_MODULUS = 1000000
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [totp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic [totp_pkg::TS_W-1:0]         s_time_step,
    input  totp_pkg::totp_cmd_t               cmd,
    output logic [totp_pkg::CODE_W-1:0]       code
);
    import totp_pkg::*;

    // The quotient estimate floor(val * RECIP / 2^31) is at most one below the
    // true quotient, so a single compare and subtract finishes the remainder.
    localparam logic [31:0] MOD_K = 32'(CODE_MODULUS);
    localparam logic [31:0] RECIP = 32'((64'd1 << 31) / 64'(CODE_MODULUS));

    logic [63:0]       key_reg [KEY_WORDS];
    logic [31:0]       h_reg   [5];
    logic [31:0]       inner_reg [5];
    logic [31:0]       wnd_reg [16];
    logic [31:0]       a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [30:0]       val_reg;
    logic [31:0]       q_reg;
    logic [31:0]       qm_reg;
    logic [31:0]       rem_reg;
    logic [CODE_W-1:0] code_reg;

    logic [31:0]  f_val, k_val, t_val, w_new, pad;
    logic [31:0]  h_start [5];
    logic [31:0]  blk_w [16];
    logic [159:0] digest;
    logic [7:0]   dig_base;
    logic [31:0]  trunc_word;
    logic [62:0]  mul_full;
    logic [31:0]  qm_next, diff, rem_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) key_reg[i] <= '0;
        end else if (cfg_valid && (cfg_index < CFG_IDX_W'(KEY_WORDS))) begin
            key_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    always_comb begin
        priority if (cmd.rnd < 7'd20) begin
            f_val = d_reg ^ (b_reg & (c_reg ^ d_reg));
            k_val = K0;
        end else if (cmd.rnd < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (cmd.rnd < 7'd60) begin
            f_val = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + k_val + e_reg + wnd_reg[0];
        w_new = wnd_reg[13] ^ wnd_reg[8] ^ wnd_reg[2] ^ wnd_reg[0];
        w_new = {w_new[30:0], w_new[31]};
    end

    // Block contents and starting chaining value for the block being loaded.
    always_comb begin
        pad = (cmd.blk == BLK_OUTER_KEY) ? OPAD : IPAD;
        for (int i = 0; i < 16; i++) blk_w[i] = '0;
        unique case (cmd.blk)
            BLK_INNER_KEY, BLK_OUTER_KEY: begin
                for (int j = 0; j < KEY_WORDS; j++) begin
                    blk_w[2*j]   = key_reg[j][63:32] ^ pad;
                    blk_w[2*j+1] = key_reg[j][31:0] ^ pad;
                end
            end
            BLK_INNER_MSG: begin
                blk_w[1]  = ts_reg;
                blk_w[2]  = PAD_WORD;
                blk_w[15] = INNER_LEN;
            end
            default: begin
                for (int i = 0; i < 5; i++) blk_w[i] = inner_reg[i];
                blk_w[5]  = PAD_WORD;
                blk_w[15] = OUTER_LEN;
            end
        endcase
        if (cmd.blk[0]) begin
            for (int i = 0; i < 5; i++) h_start[i] = h_reg[i];
        end else begin
            h_start[0] = IV0; h_start[1] = IV1; h_start[2] = IV2;
            h_start[3] = IV3; h_start[4] = IV4;
        end
    end

    always_comb begin
        digest     = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};
        dig_base   = 8'd159 - {1'b0, h_reg[4][3:0], 3'b000};
        trunc_word = digest[dig_base -: 32];
        mul_full   = 63'({1'b0, val_reg}) * 63'(RECIP);
        qm_next    = q_reg * MOD_K;
        diff       = {1'b0, val_reg} - qm_reg;
        rem_next   = (diff >= MOD_K) ? diff - MOD_K : diff;
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_START: ts_reg <= s_time_step;
            OP_LOAD: begin
                if (cmd.blk == BLK_OUTER_KEY) begin
                    for (int i = 0; i < 5; i++) inner_reg[i] <= h_reg[i];
                end
                for (int i = 0; i < 5; i++) h_reg[i] <= h_start[i];
                for (int i = 0; i < 16; i++) wnd_reg[i] <= blk_w[i];
                a_reg <= h_start[0];
                b_reg <= h_start[1];
                c_reg <= h_start[2];
                d_reg <= h_start[3];
                e_reg <= h_start[4];
            end
            OP_ROUND: begin
                for (int i = 0; i < 15; i++) wnd_reg[i] <= wnd_reg[i+1];
                wnd_reg[15] <= w_new;
                e_reg <= d_reg;
                d_reg <= c_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                b_reg <= a_reg;
                a_reg <= t_val;
            end
            OP_ADD: begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            OP_TRUNC: val_reg <= trunc_word[30:0];
            // Modulo steps in order: quotient estimate, its product, the correction.
            OP_MOD: begin
                q_reg   <= mul_full[62:31];
                qm_reg  <= qm_next;
                rem_reg <= rem_next;
            end
            OP_OUT:  code_reg <= rem_reg[CODE_W-1:0];
            default: ;
        endcase
    end

    assign code = code_reg;

endmodule

// File: rtl/core/totp_ctrl.sv
// ---------------------------------------------------------------------------
// TOTP controller
// Sequences the four compressions, truncation, modulo and result transfer.
// ---------------------------------------------------------------------------
module totp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output totp_pkg::totp_cmd_t cmd
);
    import totp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_TRUNC = 7'b0010000,
        ST_MOD   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        rnd_next     = rnd_reg;
        blk_next     = blk_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NONE;
        cmd.blk      = blk_reg;
        cmd.rnd      = rnd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_START;
                    blk_next   = BLK_INNER_KEY;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.op     = OP_LOAD;
                rnd_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.op   = OP_ROUND;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND) state_next = ST_ADD;
            end
            ST_ADD: begin
                cmd.op = OP_ADD;
                if (blk_reg == LAST_BLOCK) begin
                    state_next = ST_TRUNC;
                end else begin
                    blk_next   = blk_reg + 2'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_TRUNC: begin
                cmd.op     = OP_TRUNC;
                rnd_next   = '0;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                cmd.op   = OP_MOD;
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == LAST_MOD_STEP) state_next = ST_OUT;
            end
            ST_OUT: begin
                // The result register is reloaded only once the previous code is taken.
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rnd_reg     <= '0;
            blk_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rnd_reg     <= rnd_next;
            blk_reg     <= blk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: rtl/core/totp_code_generator.sv
// From input transfer to result valid: four SHA-1 blocks, each a load, the rounds
// and an add, on the single shared round unit, then truncation, modulo and output.
// A new time step is taken only after the previous code is loaded for output.
// A finished code waits in the output register while the next time step is taken.
// Reset (aresetn, synchronous, active low) clears the control state and the key.
// ---------------------------------------------------------------------------
// TOTP code generator
// HMAC-SHA1 over a time step with HOTP dynamic truncation and modulo.
// ---------------------------------------------------------------------------
module totp_code_generator #(
    parameter int CODE_MODULUS = 1000000
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [totp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [totp_pkg::TS_W-1:0]         s_time_step,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [totp_pkg::CODE_W-1:0]       m_code
);
    import totp_pkg::*;

    totp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    totp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    totp_datapath #(.CODE_MODULUS(CODE_MODULUS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_time_step (s_time_step),
        .cmd         (cmd),
        .code        (m_code)
    );

endmodule

// File: rtl/core/totp_checker.sv
// ---------------------------------------------------------------------------
// TOTP port assertions
// Port-level checks on the code generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "totp_code_generator_macros.svh"

module totp_assertions #(
    parameter int CODE_MODULUS = 1000000
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [totp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [63:0]                    cfg_data,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [totp_pkg::TS_W-1:0]      s_time_step,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [totp_pkg::CODE_W-1:0]    m_code
);

    // A stalled result keeps its valid.
    `TOTP_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid, "result dropped")
    // A stalled result keeps its code.
    `TOTP_ASSERT_NEXT(a_hold_code, aclk, aresetn, m_valid && !m_ready, $stable(m_code), "code changed")
    // Once a time step is taken, the block is busy with it.
    `TOTP_ASSERT_NEXT(a_busy, aclk, aresetn, s_valid && s_ready, !s_ready, "second item taken")
    // A code lies below the modulus.
    `TOTP_ASSERT_SAME(a_range, aclk, aresetn, m_valid,
        (32'(m_code) < CODE_MODULUS) || (CODE_MODULUS > 1048576), "code out of range")

endmodule

bind totp_code_generator totp_assertions #(.CODE_MODULUS(CODE_MODULUS)) u_totp_assertions (.*);
